// File: rtl/mbs_pkg.sv
// shared types and constants for the multichannel blink scheduler
package mbs_pkg;
    localparam int NUM_CHANNELS = 8;
    localparam int QUEUE_DEPTH  = 16;
    localparam int TIME_BITS    = 32;
    localparam int CH_BITS      = 3;
    localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int MEM_BITS     = CH_BITS + PTR_BITS;

    // configuration register indexes
    localparam logic [0:0] REG_SPACING = 1'd0;
    localparam logic [0:0] REG_ENABLE  = 1'd1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_SET     = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_DISABLED = 2'd2
    } status_t;

    localparam logic [1:0] LV_LOW  = 2'd0;
    localparam logic [1:0] LV_HIGH = 2'd1;

    // one request as it waits between front and back
    typedef struct packed {
        op_t                 op;
        logic [CH_BITS-1:0]  ch;
        logic [31:0]         now;
        logic [15:0]         dur;
        logic [3:0]          cnt;
        logic [15:0]         pau;
        logic                ovw;
        logic [1:0]          lv;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TICK_RD,
        BK_TICK_CMP,
        BK_ENQ_RD,
        BK_ENQ_WR,
        BK_DONE
    } bk_state_t;
endpackage

// File: rtl/multichannel_blink_scheduler.sv
// top level of the multichannel blink scheduler
// Eight output channels, each with a 16-entry ring of toggle times (15 usable)
// held in one 128-word memory. A front queue of two requests takes input while
// the back end works. A tick scans the channels one at a time with a registered
// memory read, and an enqueue writes one timestamp a cycle, at most 14 entries,
// starting after the last queued entry plus the spacing when the ring is not
// empty. Every request gives exactly one result with all pin levels and a
// status. Configuration must be written only while idle; the block does not
// enforce this.
module multichannel_blink_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [2:0]  s_channel,
    input  logic [31:0] s_now,
    input  logic [15:0] s_duration,
    input  logic [3:0]  s_pulse_count,
    input  logic [15:0] s_pause,
    input  logic        s_overwrite,
    input  logic [1:0]  s_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pin_levels,
    output logic [1:0]  m_status
);
    import mbs_pkg::*;

    // config registers
    logic [15:0] spacing_reg;
    logic        enable_reg;
    req_t        in_req, q_req;
    logic        q_valid, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= '0;
            enable_reg  <= 1'b1;
        end else if (cfg_we) begin
            if (cfg_index == REG_SPACING) spacing_reg <= cfg_data;
            else                          enable_reg  <= cfg_data[0];
        end
    end

    // pack the request fields
    always_comb begin
        in_req.op  = op_t'(s_operation);
        in_req.ch  = s_channel;
        in_req.now = s_now;
        in_req.dur = s_duration;
        in_req.cnt = s_pulse_count;
        in_req.pau = s_pause;
        in_req.ovw = s_overwrite;
        in_req.lv  = s_level;
    end

    mbs_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .in_req,
        .q_valid, .q_pop, .q_req
    );

    mbs_back u_back (
        .aclk, .aresetn, .q_valid, .q_pop, .q_req,
        .spacing(spacing_reg), .enable(enable_reg),
        .res_valid(m_valid), .res_ready(m_ready),
        .res_levels(m_pin_levels), .res_status(m_status)
    );
endmodule

// File: rtl/mbs_front.sv
// input stage and two-entry request queue
module mbs_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mbs_pkg::req_t in_req,
    output logic          q_valid,
    input  logic          q_pop,
    output mbs_pkg::req_t q_req
);
    import mbs_pkg::*;

    req_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = mem_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ (q_pop && q_valid);
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (cnt_reg != 2'd3) else $error("queue count out of range");
        end
    end
    a_full_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !s_ready) else $error("ready while full");
    a_empty_no_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !q_valid) else $error("valid while empty");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !q_pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("push lost");
endmodule

// File: rtl/mbs_back.sv
// executes requests: channel scan for ticks, timestamp writer for enqueues
module mbs_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_pop,
    input  mbs_pkg::req_t q_req,
    input  logic [15:0]   spacing,
    input  logic          enable,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [7:0]    res_levels,
    output logic [1:0]    res_status
);
    import mbs_pkg::*;

    bk_state_t state_reg, state_next;
    req_t      req_reg, req_next;
    logic [NUM_CHANNELS-1:0] lvl_reg, lvl_next;
    logic [PTR_BITS-1:0] head_reg [NUM_CHANNELS];
    logic [PTR_BITS-1:0] tail_reg [NUM_CHANNELS];
    logic [PTR_BITS-1:0] head_next [NUM_CHANNELS];
    logic [PTR_BITS-1:0] tail_next [NUM_CHANNELS];
    logic [CH_BITS-1:0]  scan_reg, scan_next;
    logic [4:0]          left_reg, left_next;
    logic                ph_reg, ph_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [1:0]          st_reg, st_next;
    logic                rv_reg, rv_next;
    logic [7:0]          ol_reg, ol_next;
    logic [1:0]          os_reg, os_next;

    logic [TIME_BITS-1:0] mem [NUM_CHANNELS*QUEUE_DEPTH];
    logic [TIME_BITS-1:0] rd_reg;
    logic [MEM_BITS-1:0]  rd_addr, wr_addr;
    logic                 rd_en, wr_en;

    logic [PTR_BITS-1:0] h, tl, cntq;
    logic [4:0]          need;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= t_reg;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        lvl_next   = lvl_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        scan_next  = scan_reg;
        left_next  = left_reg;
        ph_next    = ph_reg;
        t_next     = t_reg;
        st_next    = st_reg;
        rv_next    = rv_reg && !res_ready;
        ol_next    = ol_reg;
        os_next    = os_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = {scan_reg, head_reg[scan_reg]};
        wr_addr    = {req_reg.ch, tail_reg[req_reg.ch]};
        h          = head_reg[req_reg.ch];
        tl         = tail_reg[req_reg.ch];
        cntq       = tl - h;
        need       = (req_reg.cnt == 4'd0) ? 5'd1 : {req_reg.cnt, 1'b0};
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    req_next = q_req;
                    st_next  = ST_DONE;
                    scan_next = '0;
                    state_next = BK_DONE;
                    if (q_req.op == OP_TICK) begin
                        if (!enable) begin
                            st_next = ST_DISABLED;
                        end else begin
                            state_next = BK_TICK_RD;
                        end
                    end else if (q_req.op == OP_SET) begin
                        if (q_req.lv == LV_LOW) lvl_next[q_req.ch] = 1'b0;
                        else if (q_req.lv == LV_HIGH) lvl_next[q_req.ch] = 1'b1;
                    end else if (!enable) begin
                        st_next = ST_DISABLED;
                    end else if (q_req.op == OP_CLEAR) begin
                        if (q_req.lv == LV_LOW) lvl_next[q_req.ch] = 1'b0;
                        else if (q_req.lv == LV_HIGH) lvl_next[q_req.ch] = 1'b1;
                        head_next[q_req.ch] = '0;
                        tail_next[q_req.ch] = '0;
                    end else begin
                        if (q_req.ovw) begin
                            lvl_next[q_req.ch]  = 1'b0;
                            head_next[q_req.ch] = '0;
                            tail_next[q_req.ch] = '0;
                        end
                        state_next = BK_ENQ_RD;
                    end
                end
            end
            BK_TICK_RD: begin
                rd_en      = 1'b1;
                state_next = BK_TICK_CMP;
            end
            BK_TICK_CMP: begin
                if (head_reg[scan_reg] != tail_reg[scan_reg] && req_reg.now >= rd_reg) begin
                    lvl_next[scan_reg]  = ~lvl_reg[scan_reg];
                    head_next[scan_reg] = head_reg[scan_reg] + 1'b1;
                end
                scan_next  = scan_reg + 1'b1;
                state_next = (scan_reg == CH_BITS'(NUM_CHANNELS - 1)) ? BK_DONE : BK_TICK_RD;
            end
            BK_ENQ_RD: begin
                // read last queued timestamp; result used next state
                rd_en   = 1'b1;
                rd_addr = {req_reg.ch, tl - 1'b1};
                if (need > 5'(QUEUE_DEPTH - 1) - {1'b0, cntq}) begin
                    st_next    = ST_NO_ROOM;
                    state_next = BK_DONE;
                end else begin
                    left_next  = need;
                    ph_next    = 1'b0;
                    state_next = BK_ENQ_WR;
                    t_next     = req_reg.now;
                end
            end
            BK_ENQ_WR: begin
                if (left_reg == need && h != tl) begin
                    // first entry: start after the last one
                    t_next = rd_reg + TIME_BITS'(spacing);
                    left_next = left_reg;
                    ph_next = 1'b1;
                    if (ph_reg) begin
                        t_next = t_reg;
                    end
                end
                if (!(left_reg == need && h != tl && !ph_reg)) begin
                    wr_en = 1'b1;
                    tail_next[req_reg.ch] = tl + 1'b1;
                    left_next = left_reg - 5'd1;
                    t_next = t_reg + TIME_BITS'(((need - left_reg) % 2 == 0) ?
                                                req_reg.dur : req_reg.pau);
                    ph_next = 1'b1;
                    if (left_reg == 5'd1) state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!rv_reg || res_ready) begin
                    rv_next    = 1'b1;
                    ol_next    = 8'(lvl_reg);
                    os_next    = st_reg;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            lvl_reg   <= '0;
            rv_reg    <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            rv_reg    <= rv_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        scan_reg <= scan_next;
        left_reg <= left_next;
        ph_reg   <= ph_next;
        t_reg    <= t_next;
        st_reg   <= st_next;
        ol_reg   <= ol_next;
        os_reg   <= os_next;
    end

    assign res_valid  = rv_reg;
    assign res_levels = ol_reg;
    assign res_status = os_reg;

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == BK_IDLE) else $error("pop outside idle");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        rv_reg && !res_ready |=> rv_reg && $stable(ol_reg))
        else $error("result dropped");
    a_write_enq: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == BK_ENQ_WR) else $error("stray write");
endmodule

// File: tb/multichannel_blink_scheduler_checker.sv
// checker for the blink scheduler: mirrors its state, predicts each result and compares
module multichannel_blink_scheduler_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [2:0]  s_channel,
    input  logic [31:0] s_now,
    input  logic [15:0] s_duration,
    input  logic [3:0]  s_pulse_count,
    input  logic [15:0] s_pause,
    input  logic        s_overwrite,
    input  logic [1:0]  s_level,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_pin_levels,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          reject_count
);
    import mbs_pkg::*;

    typedef struct {
        logic [7:0] levels;
        status_t    status;
    } blink_result_t;

    blink_result_t       expected_results[$];
    logic [15:0]         spacing;
    logic                enabled;
    logic [NUM_CHANNELS-1:0] pins;
    logic [TIME_BITS-1:0] times[NUM_CHANNELS][QUEUE_DEPTH];
    logic [PTR_BITS-1:0] head[NUM_CHANNELS];
    logic [PTR_BITS-1:0] tail[NUM_CHANNELS];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void push_time(input int c, input logic [TIME_BITS-1:0] t);
        times[c][tail[c]] = t;
        tail[c] = tail[c] + 1'b1;
    endfunction

    function automatic void apply_level(input int c, input logic [1:0] lv);
        if (lv == LV_LOW) pins[c] = 1'b0;
        else if (lv == LV_HIGH) pins[c] = 1'b1;
    endfunction

    function automatic blink_result_t predict_levels(input op_t op, input int c,
        input logic [31:0] now, input logic [15:0] dur, input logic [3:0] cnt,
        input logic [15:0] pau, input logic ovw, input logic [1:0] lv);
        blink_result_t r;
        int need;
        int used;
        logic [TIME_BITS-1:0] t;
        r.status = ST_DONE;
        if (op == OP_TICK) begin
            if (!enabled) r.status = ST_DISABLED;
            else begin
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    if (head[k] != tail[k] && now >= times[k][head[k]]) begin
                        pins[k] = ~pins[k];
                        head[k] = head[k] + 1'b1;
                    end
                end
            end
        end else if (op == OP_SET) begin
            apply_level(c, lv);
        end else if (!enabled) begin
            r.status = ST_DISABLED;
        end else if (op == OP_CLEAR) begin
            apply_level(c, lv);
            head[c] = '0;
            tail[c] = '0;
        end else begin
            need = (cnt == 0) ? 1 : 2 * cnt;
            if (ovw) begin
                pins[c] = 1'b0;
                head[c] = '0;
                tail[c] = '0;
            end
            used = int'(PTR_BITS'(tail[c] - head[c]));
            if (need > QUEUE_DEPTH - 1 - used) r.status = ST_NO_ROOM;
            else begin
                if (head[c] == tail[c]) t = now;
                else t = times[c][PTR_BITS'(tail[c] - 1'b1)] + spacing;
                push_time(c, t);
                for (int i = 0; i < cnt; i++) begin
                    t = t + dur;
                    push_time(c, t);
                    if (i + 1 != cnt) begin
                        t = t + pau;
                        push_time(c, t);
                    end
                end
            end
        end
        r.levels = pins;
        return r;
    endfunction

    always @(posedge aclk) begin
        blink_result_t want;
        if (!aresetn) begin
            spacing = '0;
            enabled = 1'b1;
            pins = '0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                head[k] = '0;
                tail[k] = '0;
            end
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
            reject_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_SPACING) spacing = cfg_data;
                else if (cfg_index == REG_ENABLE) enabled = cfg_data[0];
            end
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_pin_levels, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_pin_levels !== want.levels)
                        report_mismatch("pin_levels", m_pin_levels, want.levels);
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (want.status == ST_NO_ROOM) reject_count++;
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_levels(op_t'(s_operation), s_channel,
                    s_now, s_duration, s_pulse_count, s_pause, s_overwrite, s_level));
        end
        pending_count = expected_results.size();
    end
endmodule

// File: tb/multichannel_blink_scheduler_tb.sv
// testbench top for the blink scheduler: stimulus, idling, watchdog and verdict
module multichannel_blink_scheduler_tb;
    import mbs_pkg::*;

    localparam int RANDOM_REQUESTS = 1530;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 80;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [2:0]  s_channel;
    logic [31:0] s_now;
    logic [15:0] s_duration;
    logic [3:0]  s_pulse_count;
    logic [15:0] s_pause;
    logic        s_overwrite;
    logic [1:0]  s_level;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_pin_levels;
    logic [1:0]  m_status;

    int fail_count;
    int pending_count;
    int result_count;
    int reject_count;

    // idle percentages per side, changed by the stimulus phases
    int send_idle_pct;
    int recv_idle_pct;
    // long receiver hold-off, counted down in the receiver process
    int recv_hold_cycles;
    int idle_cycles;
    int sent_count;
    // running time base so ticks mostly move forward
    logic [31:0] clock_ms;

    multichannel_blink_scheduler uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_channel(s_channel), .s_now(s_now),
        .s_duration(s_duration), .s_pulse_count(s_pulse_count), .s_pause(s_pause),
        .s_overwrite(s_overwrite), .s_level(s_level),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pin_levels(m_pin_levels), .m_status(m_status)
    );

    multichannel_blink_scheduler_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random ready at the falling edge, or a long hold-off
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (recv_hold_cycles > 0) begin
            m_ready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles with no request and no result accepted
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", idle_cycles);
            $display("FAIL multichannel_blink_scheduler");
            $finish;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // offer one request and hold it until accepted; valid drops only when the sender idles
    task automatic send_request(input op_t op, input logic [2:0] ch, input logic [31:0] now,
        input logic [15:0] dur, input logic [3:0] cnt, input logic [15:0] pau,
        input logic ovw, input logic [1:0] lv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_channel     <= ch;
        s_now         <= now;
        s_duration    <= dur;
        s_pulse_count <= cnt;
        s_pause       <= pau;
        s_overwrite   <= ovw;
        s_level       <= lv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    // wait for every result, then let the back end settle before a register write
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // one random request; mostly short patterns and forward-moving ticks
    task automatic send_random();
        op_t         op;
        logic [15:0] dur;
        logic [15:0] pau;
        logic [3:0]  cnt;
        logic [31:0] now;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 40) op = OP_TICK;
        else if (pick < 75) op = OP_ENQUEUE;
        else if (pick < 88) op = OP_SET;
        else op = OP_CLEAR;
        // small timing mostly, full range now and then
        dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60));
        pau = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60));
        cnt = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(4));
        clock_ms = clock_ms + $urandom_range(80);
        // occasional wild time to hit wrap and far-future cases
        now = ($urandom_range(19) == 0) ? $urandom : clock_ms;
        send_request(op, 3'($urandom), now, dur, cnt, pau,
            ($urandom_range(5) == 0), 2'($urandom));
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SPACING;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_operation   = OP_TICK;
        s_channel     = '0;
        s_now         = '0;
        s_duration    = '0;
        s_pulse_count = '0;
        s_pause       = '0;
        s_overwrite   = 1'b0;
        s_level       = LV_LOW;
        m_ready       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 0;
        idle_cycles   = 0;
        sent_count    = 0;
        clock_ms      = 32'd1000;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: levels, all ops, extremes of every field
        write_reg(REG_SPACING, 16'd5);
        write_reg(REG_ENABLE, 16'd1);
        send_request(OP_SET, 3'd7, 32'd0, 16'd0, 4'd0, 16'd0, 1'b0, LV_HIGH);
        send_request(OP_SET, 3'd0, 32'd0, 16'd0, 4'd0, 16'd0, 1'b0, LV_HIGH);
        send_request(OP_SET, 3'd0, 32'd0, 16'd0, 4'd0, 16'd0, 1'b0, 2'd2);
        // level code three keeps the level
        send_request(OP_SET, 3'd7, 32'd0, 16'd0, 4'd0, 16'd0, 1'b0, 2'd3);
        // single toggle, then append with spacing
        send_request(OP_ENQUEUE, 3'd1, 32'd100, 16'd10, 4'd0, 16'd0, 1'b0, LV_LOW);
        send_request(OP_ENQUEUE, 3'd1, 32'd100, 16'd10, 4'd2, 16'd20, 1'b0, LV_LOW);
        send_request(OP_TICK, 3'd0, 32'd99, 16'd0, 4'd0, 16'd0, 1'b0, LV_LOW);
        send_request(OP_TICK, 3'd0, 32'd100, 16'd0, 4'd0, 16'd0, 1'b0, LV_LOW);
        send_request(OP_TICK, 3'd0, 32'hFFFF_FFFF, 16'd0, 4'd0, 16'd0, 1'b0, LV_LOW);
        // ring too full: 15 pulses need 30 entries
        send_request(OP_ENQUEUE, 3'd2, 32'd0, 16'hFFFF, 4'd15, 16'hFFFF, 1'b0, LV_LOW);
        // 7 pulses take 14 entries, a single toggle fills the ring, one more pulse is rejected
        send_request(OP_ENQUEUE, 3'd3, 32'hFFFF_FF00, 16'hFFFF, 4'd7, 16'hFFFF, 1'b0, LV_LOW);
        send_request(OP_ENQUEUE, 3'd3, 32'd0, 16'd1, 4'd0, 16'd1, 1'b0, LV_LOW);
        send_request(OP_ENQUEUE, 3'd3, 32'd0, 16'd1, 4'd1, 16'd1, 1'b0, LV_LOW);
        // overwrite clears first, even when the result is a rejection
        send_request(OP_ENQUEUE, 3'd0, 32'd5, 16'd3, 4'd15, 16'd3, 1'b1, LV_LOW);
        send_request(OP_ENQUEUE, 3'd3, 32'd50, 16'd3, 4'd2, 16'd3, 1'b1, LV_LOW);
        send_request(OP_CLEAR, 3'd3, 32'd0, 16'd0, 4'd0, 16'd0, 1'b0, LV_HIGH);
        send_request(OP_CLEAR, 3'd1, 32'd0, 16'd0, 4'd0, 16'd0, 1'b0, 2'd2);
        drain_results();
        // disabled queueing: only set works
        write_reg(REG_ENABLE, 16'd0);
        write_reg(REG_SPACING, 16'hFFFF);
        send_request(OP_TICK, 3'd0, 32'hFFFF_FFFF, 16'd0, 4'd0, 16'd0, 1'b0, LV_LOW);
        send_request(OP_ENQUEUE, 3'd4, 32'd1, 16'd1, 4'd1, 16'd1, 1'b1, LV_LOW);
        send_request(OP_CLEAR, 3'd3, 32'd0, 16'd0, 4'd0, 16'd0, 1'b0, LV_LOW);
        send_request(OP_SET, 3'd5, 32'd0, 16'd0, 4'd0, 16'd0, 1'b0, LV_HIGH);
        drain_results();
        write_reg(REG_ENABLE, 16'd1);

        // random phases with changing idling and spacing
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_REQUESTS / 6; n++) begin
                // long receiver hold-off so the input side backs up
                if (n == 40) recv_hold_cycles = 400;
                // sender pause until all results are in
                if (n == 120) begin
                    s_valid <= 1'b0;
                    while (pending_count != 0) @(negedge aclk);
                end
                send_random();
            end
            drain_results();
            case (phase)
                0: write_reg(REG_SPACING, 16'hFFFF);
                1: write_reg(REG_SPACING, 16'd0);
                2: write_reg(REG_ENABLE, 16'd0);
                3: write_reg(REG_ENABLE, 16'd1);
                default: write_reg(REG_SPACING, 16'($urandom_range(50)));
            endcase
        end

        drain_results();
        $display("covered %0d requests, %0d results, %0d rejected for lack of room",
            sent_count, result_count, reject_count);
        $display("register settings swept: spacing 0, small, max; queueing on and off");
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS multichannel_blink_scheduler");
        end else begin
            $display("FAIL multichannel_blink_scheduler");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/mbs_pkg.sv
rtl/mbs_front.sv
rtl/mbs_back.sv
rtl/multichannel_blink_scheduler.sv
tb/multichannel_blink_scheduler_checker.sv
tb/multichannel_blink_scheduler_tb.sv
